FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/eia_pkg.sv
// Types and constants of the entity id allocator.
package eia_pkg;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned ID_IN_W    = 16;
  localparam int unsigned SIG_IN_W   = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ENT_OUT_W  = 10;
  localparam int unsigned SIG_OUT_W  = 32;
  localparam int unsigned LIVE_OUT_W = 11;

  localparam int unsigned CMD_FIFO_DEPTH = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_SET     = 2'd2,
    OP_GET     = 2'd3
  } eia_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NONE_FREE    = 2'd1,
    ST_RANGE        = 2'd2,
    ST_NOTHING_LIVE = 2'd3
  } eia_status_e;

  typedef struct packed {
    eia_op_e     op;
    eia_status_e status;
  } eia_ctl_t;

endpackage

FILE: hw/rtl/eia_if.sv
// Request and response channel interfaces of the entity id allocator.
interface eia_req_if;
  import eia_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ID_IN_W-1:0]  entity_id;
  logic [SIG_IN_W-1:0] signature_in;

  modport source (output valid, opcode, entity_id, signature_in, input ready);
  modport sink   (input valid, opcode, entity_id, signature_in, output ready);
endinterface

interface eia_rsp_if;
  import eia_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [ENT_OUT_W-1:0]  entity_out;
  logic [SIG_OUT_W-1:0]  signature_out;
  logic [LIVE_OUT_W-1:0] live_count;

  modport source (output valid, status, entity_out, signature_out, live_count, input ready);
  modport sink   (input valid, status, entity_out, signature_out, live_count, output ready);
endinterface

FILE: hw/rtl/eia_cmd_fifo.sv
// Command queue between the classifying front and the executing back.
`include "assert_macros.svh"

module eia_cmd_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] rdata_o
);
  import eia_pkg::*;

  localparam int unsigned PTR_W = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CMD_FIFO_DEPTH);

  logic [DATA_W-1:0] mem_q [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, !full_o, "push into full command queue")
  `ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, valid_o, "pop from empty command queue")

endmodule

FILE: hw/rtl/eia_front.sv
// Front end: accepts requests, checks them and tracks queue pointers and live count.
`include "assert_macros.svh"

module eia_front #(
  parameter int unsigned ENTITY_COUNT   = 1024,
  parameter int unsigned SIGNATURE_BITS = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  eia_req_if.sink                                   req_i,
  input  logic                                      clr_busy_i,
  input  logic                                      cmd_full_i,
  output logic                                      cmd_push_o,
  output eia_pkg::eia_ctl_t                         cmd_ctl_o,
  output logic [$clog2(ENTITY_COUNT)-1:0]           cmd_id_o,
  output logic [$clog2(ENTITY_COUNT)-1:0]           cmd_pos_o,
  output logic                                      cmd_init_o,
  output logic [$clog2(ENTITY_COUNT+1)-1:0]         cmd_live_o,
  output logic [SIGNATURE_BITS-1:0]                 cmd_sig_o
);
  import eia_pkg::*;

  localparam int unsigned IDW = $clog2(ENTITY_COUNT);
  localparam int unsigned LCW = $clog2(ENTITY_COUNT + 1);
  localparam logic [IDW-1:0] LAST_POS = IDW'(ENTITY_COUNT - 1);
  localparam logic [LCW-1:0] LIVE_MAX = LCW'(ENTITY_COUNT);
  localparam logic [ID_IN_W:0] ID_LIMIT = (ID_IN_W + 1)'(ENTITY_COUNT);

  logic [IDW-1:0] head_q, head_d, tail_q, tail_d;
  logic           wrapped_q, wrapped_d;
  logic [LCW-1:0] live_q, live_d;
  eia_op_e        op;
  eia_status_e    st;
  logic           accept, ok, range_bad;

  assign op         = eia_op_e'(req_i.opcode);
  assign req_i.ready = !clr_busy_i && !cmd_full_i;
  assign accept     = req_i.valid && req_i.ready;
  assign range_bad  = ({1'b0, req_i.entity_id} >= ID_LIMIT);

  always_comb begin
    st = ST_OK;
    unique case (op)
      OP_CREATE: begin
        if (live_q == LIVE_MAX) st = ST_NONE_FREE;
      end
      OP_DESTROY: begin
        if (range_bad) st = ST_RANGE;
        else if (live_q == '0) st = ST_NOTHING_LIVE;
      end
      OP_SET, OP_GET: begin
        if (range_bad) st = ST_RANGE;
      end
    endcase
  end

  assign ok = (st == ST_OK);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    wrapped_d = wrapped_q;
    live_d    = live_q;
    if (accept && ok) begin
      unique case (op)
        OP_CREATE: begin
          head_d = (head_q == LAST_POS) ? '0 : head_q + 1'b1;
          live_d = live_q + 1'b1;
        end
        OP_DESTROY: begin
          tail_d    = (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
          wrapped_d = wrapped_q || (tail_q == LAST_POS);
          live_d    = live_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      wrapped_q <= 1'b0;
      live_q    <= '0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      wrapped_q <= wrapped_d;
      live_q    <= live_d;
    end
  end

  // cmd_init_o flags a create whose queue slot was never written; its position serves as the id
  assign cmd_push_o = accept;
  assign cmd_ctl_o  = '{op: op, status: st};
  assign cmd_id_o   = req_i.entity_id[IDW-1:0];
  assign cmd_pos_o  = (op == OP_CREATE) ? head_q : tail_q;
  assign cmd_init_o = !wrapped_q && (head_q >= tail_q);
  assign cmd_live_o = live_d;
  assign cmd_sig_o  = SIGNATURE_BITS'(req_i.signature_in);

  `ASSERT_ALWAYS(a_live_bound, clk_i, rst_ni, live_q <= LIVE_MAX, "live count above entity count")
  `ASSERT_NEXT(a_create_inc, clk_i, rst_ni,
               accept && ok && (op == OP_CREATE),
               live_q == LCW'($past(live_q) + 1'b1),
               "create did not count up")

endmodule

FILE: hw/rtl/eia_back.sv
// Back end: queue and signature memories, clearing pass and response register.
`include "assert_macros.svh"

module eia_back #(
  parameter int unsigned ENTITY_COUNT   = 1024,
  parameter int unsigned SIGNATURE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_pop_o,
  input  eia_pkg::eia_ctl_t                 cmd_ctl_i,
  input  logic [$clog2(ENTITY_COUNT)-1:0]   cmd_id_i,
  input  logic [$clog2(ENTITY_COUNT)-1:0]   cmd_pos_i,
  input  logic                              cmd_init_i,
  input  logic [$clog2(ENTITY_COUNT+1)-1:0] cmd_live_i,
  input  logic [SIGNATURE_BITS-1:0]         cmd_sig_i,
  output logic                              clr_busy_o,
  eia_rsp_if.source                         rsp_o
);
  import eia_pkg::*;

  localparam int unsigned IDW = $clog2(ENTITY_COUNT);
  localparam int unsigned LCW = $clog2(ENTITY_COUNT + 1);
  localparam int unsigned SW  = SIGNATURE_BITS;
  localparam logic [IDW-1:0] LAST_POS = IDW'(ENTITY_COUNT - 1);

  logic [IDW-1:0] qmem [ENTITY_COUNT];
  logic [SW-1:0]  smem [ENTITY_COUNT];

  logic           clr_busy_q;
  logic [IDW-1:0] clr_cnt_q;

  logic           issue, c_ok, q_we, q_re, s_re, s_we;
  logic [IDW-1:0] s_addr;
  logic [SW-1:0]  s_wdata;
  logic [IDW-1:0] q_rd_q;
  logic [SW-1:0]  s_rd_q;

  logic           a_valid_q, a_adv;
  eia_ctl_t       a_ctl_q;
  logic [IDW-1:0] a_id_q, a_pos_q;
  logic           a_init_q;
  logic [LCW-1:0] a_live_q;

  logic                  out_valid_q;
  eia_status_e           out_status_q;
  logic [ENT_OUT_W-1:0]  out_ent_q;
  logic [SIG_OUT_W-1:0]  out_sig_q;
  logic [LIVE_OUT_W-1:0] out_live_q;
  logic [IDW-1:0]        ent_w;
  logic [SW-1:0]         sig_w;
  logic                  a_ok;

  assign a_adv     = a_valid_q && (!out_valid_q || rsp_o.ready);
  assign issue     = cmd_valid_i && !clr_busy_q && (!a_valid_q || a_adv);
  assign cmd_pop_o = issue;
  assign c_ok      = (cmd_ctl_i.status == ST_OK);
  assign q_we      = issue && c_ok && (cmd_ctl_i.op == OP_DESTROY);
  assign q_re      = issue && c_ok && (cmd_ctl_i.op == OP_CREATE);
  assign s_re      = issue && c_ok && (cmd_ctl_i.op == OP_GET);
  assign clr_busy_o = clr_busy_q;

  always_comb begin
    s_we    = 1'b0;
    s_addr  = cmd_id_i;
    s_wdata = '0;
    priority if (clr_busy_q) begin
      s_we   = 1'b1;
      s_addr = clr_cnt_q;
    end else if (issue && c_ok) begin
      unique case (cmd_ctl_i.op)
        OP_DESTROY: s_we = 1'b1;
        OP_SET: begin
          s_we    = 1'b1;
          s_wdata = cmd_sig_i;
        end
        default: ;
      endcase
    end else begin
      s_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[cmd_pos_i] <= cmd_id_i;
    end
    if (q_re) begin
      q_rd_q <= qmem[cmd_pos_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[s_addr] <= s_wdata;
    end
    if (s_re) begin
      s_rd_q <= smem[cmd_id_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= (clr_cnt_q == LAST_POS) ? '0 : clr_cnt_q + 1'b1;
      if (clr_cnt_q == LAST_POS) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (issue) begin
      a_valid_q <= 1'b1;
    end else if (a_adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_ctl_q  <= cmd_ctl_i;
      a_id_q   <= cmd_id_i;
      a_pos_q  <= cmd_pos_i;
      a_init_q <= cmd_init_i;
      a_live_q <= cmd_live_i;
    end
  end

  assign a_ok = (a_ctl_q.status == ST_OK);

  always_comb begin
    ent_w = '0;
    sig_w = '0;
    if (a_ok) begin
      unique case (a_ctl_q.op)
        OP_CREATE: ent_w = a_init_q ? a_pos_q : q_rd_q;
        OP_GET: begin
          ent_w = a_id_q;
          sig_w = s_rd_q;
        end
        OP_DESTROY, OP_SET: ent_w = a_id_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (a_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      out_status_q <= a_ctl_q.status;
      out_ent_q    <= ENT_OUT_W'(ent_w);
      out_sig_q    <= SIG_OUT_W'(sig_w);
      out_live_q   <= LIVE_OUT_W'(a_live_q);
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.entity_out    = out_ent_q;
  assign rsp_o.signature_out = out_sig_q;
  assign rsp_o.live_count    = out_live_q;

  `ASSERT_IMPL(a_no_issue_clr, clk_i, rst_ni, clr_busy_q, !issue, "command issued during clear")
  `ASSERT_IMPL(a_stage_hold, clk_i, rst_ni, a_valid_q && !a_adv, !issue,
               "pending stage overwritten")

endmodule

FILE: hw/rtl/entity_id_allocator.sv
// Top level of the entity id allocator: front end, command queue and back end.
// Each request beat (create, destroy, set or get signature) yields one response beat.
// Requests are checked in the front end, which keeps the free-queue pointers and the
// live count, and are carried out by the back end, with at most one free-queue memory
// access and at most one signature memory access per beat. Sustained rate is one beat
// per cycle while the response side keeps up; an accepted request passes through the
// command queue, the back end's issue stage and the response register. After reset the
// signature memory is cleared one word per cycle, and req_i.ready stays low until
// every word is cleared. The free queue needs no clearing: a create whose slot was
// never written takes the slot's position as its id. Double frees are not detected.
module entity_id_allocator #(
  parameter int unsigned ENTITY_COUNT   = 1024,
  parameter int unsigned SIGNATURE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  eia_req_if.sink   req_i,
  eia_rsp_if.source rsp_o
);
  import eia_pkg::*;

  localparam int unsigned IDW    = $clog2(ENTITY_COUNT);
  localparam int unsigned LCW    = $clog2(ENTITY_COUNT + 1);
  localparam int unsigned SW     = SIGNATURE_BITS;
  localparam int unsigned CTL_W  = $bits(eia_ctl_t);
  localparam int unsigned CMD_W  = CTL_W + IDW + IDW + 1 + LCW + SW;

  logic           clr_busy, cmd_full, cmd_push, cmd_pop, cmd_valid;
  eia_ctl_t       f_ctl, b_ctl;
  logic [IDW-1:0] f_id, f_pos, b_id, b_pos;
  logic           f_init, b_init;
  logic [LCW-1:0] f_live, b_live;
  logic [SW-1:0]  f_sig, b_sig;
  logic [CMD_W-1:0] cmd_wdata, cmd_rdata;

  eia_front #(
    .ENTITY_COUNT  (ENTITY_COUNT),
    .SIGNATURE_BITS(SIGNATURE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .clr_busy_i (clr_busy),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_ctl_o  (f_ctl),
    .cmd_id_o   (f_id),
    .cmd_pos_o  (f_pos),
    .cmd_init_o (f_init),
    .cmd_live_o (f_live),
    .cmd_sig_o  (f_sig)
  );

  assign cmd_wdata = {f_ctl, f_id, f_pos, f_init, f_live, f_sig};

  eia_cmd_fifo #(
    .DATA_W(CMD_W)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wdata),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .rdata_o(cmd_rdata)
  );

  assign {b_ctl, b_id, b_pos, b_init, b_live, b_sig} = cmd_rdata;

  eia_back #(
    .ENTITY_COUNT  (ENTITY_COUNT),
    .SIGNATURE_BITS(SIGNATURE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cmd_ctl_i  (b_ctl),
    .cmd_id_i   (b_id),
    .cmd_pos_i  (b_pos),
    .cmd_init_i (b_init),
    .cmd_live_i (b_live),
    .cmd_sig_i  (b_sig),
    .clr_busy_o (clr_busy),
    .rsp_o      (rsp_o)
  );

endmodule
